// ===== hdl/lcabl_pkg.sv =====
`default_nettype none

package lcabl_pkg;

	// fixed field widths
	localparam int NODE_W   = 10;
	localparam int DEPTH_W  = 10;
	localparam int STATUS_W = 2;

	// item operation
	typedef enum logic {
		OP_ATTACH = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	// result status
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_DUP    = 2'd2
	} status_t;

	// per-node entry of the node memory
	typedef struct packed {
		logic               present;
		logic [DEPTH_W-1:0] depth;
	} info_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_ATT,
		S_LIFT,
		S_MEET,
		S_CLIMB,
		S_FINAL,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/lowest_common_ancestor_binary_lifting_top.sv =====
// Lowest common ancestor engine over a rooted tree (node 0 is the root), binary lifting.
// Input channel (in_valid/in_ready) carries operation, node_a, node_b. An attach beat
// (operation 0) hangs child node_a under parent node_b; a query beat (operation 1) asks
// for the lowest common ancestor of node_a and node_b. Every input beat yields exactly one
// output beat (out_valid/out_ready) with ancestor and status (0 ok, 1 node not in the
// tree, 2 child already present); ancestor is zero for attach and for every error.
// A rejected item goes from the decide state straight to the output state; an attach
// writes one ancestor entry per level, and a query lifts the deeper node level by level,
// then, unless the two have met, climbs both level by level. One item is in work at a
// time: each lift step reads the ancestor memory at an address given by the previous
// read. The next input beat is taken in the cycle after a result moves into the output register.
// The output register holds a finished result while the receiver stalls; the next item
// is worked on meanwhile and waits only for the register to free before finishing.
// After reset a clearing pass initializes the node memory (only the root present, all
// depths zero) and the root's ancestor row; in_ready stays low during that pass.
`default_nettype none

module lowest_common_ancestor_binary_lifting_top #(
	parameter int NODE_COUNT  = 1024,
	parameter int LIFT_LEVELS = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           operation,
	input  wire logic [lcabl_pkg::NODE_W-1:0]   node_a,
	input  wire logic [lcabl_pkg::NODE_W-1:0]   node_b,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [lcabl_pkg::NODE_W-1:0]        ancestor,
	output logic [lcabl_pkg::STATUS_W-1:0]      status
);

	import lcabl_pkg::*;

	localparam int AW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int TAB_DEPTH = NODE_COUNT * (1 << LW);
	localparam int CLR_LEN   = (NODE_COUNT > LIFT_LEVELS) ? NODE_COUNT : LIFT_LEVELS;
	localparam int CW        = $clog2(CLR_LEN);
	localparam logic [LW-1:0] LAST_LVL = LW'(LIFT_LEVELS - 1);
	localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);

	// memories
	info_t             info_mem [NODE_COUNT];
	logic [NODE_W-1:0] tab_mem  [TAB_DEPTH];

	// control state
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            out_valid_q;
	logic            out_load;

	// datapath registers
	op_t                    op_q;
	logic [NODE_W-1:0]      a_q, b_q;
	logic [NODE_W-1:0]      u_q, u_d, v_q, v_d;
	logic [LW-1:0]          j_q, j_d;
	logic [LIFT_LEVELS-1:0] diff_q, diff_d;
	logic                   pend_q, pend_d;
	logic [NODE_W-1:0]      res_anc_q, res_anc_d;
	status_t                res_st_q, res_st_d;
	logic [NODE_W-1:0]      ancestor_q;
	status_t                status_q;

	// memory ports
	info_t             info_a_q, info_b_q;
	logic              info_we;
	logic [AW-1:0]     info_wa;
	info_t             info_wd;
	logic [NODE_W-1:0] tab_u_q, tab_v_q;
	logic              tab_we;
	logic [AW+LW-1:0]  tab_wa, tab_ra_u, tab_ra_v;
	logic [NODE_W-1:0] tab_wd;

	// helpers
	logic              a_rng, b_rng, a_ok, b_ok, deeper_b, differ;
	logic [NODE_W-1:0] u_cur, u_step, v_step;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;
	assign status    = status_q;

	// node memory: two read ports on the incoming node numbers, one write port
	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_wa] <= info_wd;
		end
		info_a_q <= info_mem[AW'(node_a)];
		info_b_q <= info_mem[AW'(node_b)];
	end

	// ancestor memory: row per node, one entry per level, two read ports
	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[tab_wa] <= tab_wd;
		end
		tab_u_q <= tab_mem[tab_ra_u];
		tab_v_q <= tab_mem[tab_ra_v];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op_t'(operation);
			a_q  <= node_a;
			b_q  <= node_b;
		end
		u_q       <= u_d;
		v_q       <= v_d;
		j_q       <= j_d;
		diff_q    <= diff_d;
		pend_q    <= pend_d;
		res_anc_q <= res_anc_d;
		res_st_q  <= res_st_d;
		if (out_load) begin
			ancestor_q <= res_anc_q;
			status_q   <= res_st_q;
		end
	end

	// checks and step selections
	always_comb begin
		a_rng    = (32'(a_q) < 32'(NODE_COUNT));
		b_rng    = (32'(b_q) < 32'(NODE_COUNT));
		a_ok     = a_rng && info_a_q.present;
		b_ok     = b_rng && info_b_q.present;
		deeper_b = (info_a_q.depth < info_b_q.depth);
		u_cur    = pend_q ? tab_u_q : u_q;
		differ   = (tab_u_q != tab_v_q);
		u_step   = differ ? tab_u_q : u_q;
		v_step   = differ ? tab_v_q : v_q;
	end

	// sequencer: next state and memory controls
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		out_load  = 1'b0;
		info_we   = 1'b0;
		info_wa   = AW'(a_q);
		info_wd   = '0;
		tab_we    = 1'b0;
		tab_wa    = {AW'(a_q), j_q};
		tab_wd    = tab_u_q;
		tab_ra_u  = '0;
		tab_ra_v  = '0;
		u_d       = u_q;
		v_d       = v_q;
		j_d       = j_q;
		diff_d    = diff_q;
		pend_d    = 1'b0;
		res_anc_d = res_anc_q;
		res_st_d  = res_st_q;
		unique case (state_q)
			S_CLEAR: begin
				// node entries and, alongside them, the root's all-zero ancestor row
				if (32'(cnt_q) < 32'(NODE_COUNT)) begin
					info_we         = 1'b1;
					info_wa         = AW'(cnt_q);
					info_wd.present = (cnt_q == '0);
					info_wd.depth   = '0;
				end
				if (32'(cnt_q) < 32'(LIFT_LEVELS)) begin
					tab_we = 1'b1;
					tab_wa = {{AW{1'b0}}, LW'(cnt_q)};
					tab_wd = '0;
				end
				if (cnt_q == CLR_LAST) begin
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				res_anc_d = '0;
				res_st_d  = ST_OK;
				if (op_q == OP_ATTACH) begin
					if (!a_rng || !b_ok) begin
						res_st_d = ST_ABSENT;
						state_d  = S_OUT;
					end else if (info_a_q.present) begin
						res_st_d = ST_DUP;
						state_d  = S_OUT;
					end else begin
						// record depth, level 0 is the parent, fetch parent's level 0
						info_we         = 1'b1;
						info_wd.present = 1'b1;
						info_wd.depth   = info_b_q.depth + 1'b1;
						tab_we          = 1'b1;
						tab_wa          = {AW'(a_q), LW'(0)};
						tab_wd          = b_q;
						tab_ra_u        = {AW'(b_q), LW'(0)};
						j_d             = LW'(1);
						state_d         = (LIFT_LEVELS == 1) ? S_OUT : S_ATT;
					end
				end else begin
					if (!a_ok || !b_ok) begin
						res_st_d = ST_ABSENT;
						state_d  = S_OUT;
					end else begin
						// u is the deeper node, diff the depth gap
						if (deeper_b) begin
							u_d    = b_q;
							v_d    = a_q;
							diff_d = LIFT_LEVELS'(info_b_q.depth - info_a_q.depth);
						end else begin
							u_d    = a_q;
							v_d    = b_q;
							diff_d = LIFT_LEVELS'(info_a_q.depth - info_b_q.depth);
						end
						j_d     = LAST_LVL;
						state_d = S_LIFT;
					end
				end
			end
			S_ATT: begin
				// level j of the child is level j-1 of its level j-1 ancestor
				tab_we   = 1'b1;
				tab_wa   = {AW'(a_q), j_q};
				tab_wd   = tab_u_q;
				tab_ra_u = {AW'(tab_u_q), j_q};
				if (j_q == LAST_LVL) begin
					state_d = S_OUT;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_LIFT: begin
				// lift u by the depth gap, highest level first
				u_d = u_cur;
				if (diff_q[LIFT_LEVELS-1]) begin
					tab_ra_u = {AW'(u_cur), j_q};
					pend_d   = 1'b1;
				end
				diff_d = diff_q << 1;
				if (j_q == '0) begin
					state_d = S_MEET;
				end else begin
					j_d = j_q - 1'b1;
				end
			end
			S_MEET: begin
				u_d = u_cur;
				if (u_cur == v_q) begin
					res_anc_d = u_cur;
					state_d   = S_OUT;
				end else begin
					tab_ra_u = {AW'(u_cur), LAST_LVL};
					tab_ra_v = {AW'(v_q), LAST_LVL};
					j_d      = LAST_LVL;
					state_d  = S_CLIMB;
				end
			end
			S_CLIMB: begin
				// climb both while their ancestors differ
				u_d = u_step;
				v_d = v_step;
				if (j_q == '0) begin
					tab_ra_u = {AW'(u_step), LW'(0)};
					state_d  = S_FINAL;
				end else begin
					tab_ra_u = {AW'(u_step), j_q - 1'b1};
					tab_ra_v = {AW'(v_step), j_q - 1'b1};
					j_d      = j_q - 1'b1;
				end
			end
			S_FINAL: begin
				res_anc_d = tab_u_q;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/lcabl_checker.sv =====
`default_nettype none

module lcabl_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [lcabl_pkg::NODE_W-1:0]   ancestor,
	input wire logic [lcabl_pkg::STATUS_W-1:0] status
);

	import lcabl_pkg::*;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ancestor) && $stable(status))
	else $error("stalled result beat changed");

	// only the three status codes are produced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_ABSENT || status == ST_DUP))
	else $error("undefined status code");

	// errors carry a zero ancestor
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> ancestor == '0)
	else $error("error result with nonzero ancestor");

	// one item at a time: busy right after an input beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken while an item is in work");

endmodule

bind lowest_common_ancestor_binary_lifting_top lcabl_checker u_lcabl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ancestor  (ancestor),
	.status    (status)
);

`default_nettype wire
